// ----- rtl/pms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg: shared types, constants and helpers for the pixel match block
// Holds the field widths, counter bound, controller states, register
// indexes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Field widths.
  localparam int CH_W   = 8;
  localparam int NCH_W  = 3;
  localparam int CNT_W  = 26;
  localparam int Q_W    = 15;
  localparam int PROD_W = CNT_W + Q_W;
  localparam int ITER_W = 4;

  // Counter bound and percentage scale (100 times 256).
  localparam logic [CNT_W-1:0]  MAX_PIXELS = CNT_W'(33554432);
  localparam logic [Q_W-1:0]    PCT_Q8     = Q_W'(25600);
  localparam logic [ITER_W-1:0] LAST_ITER  = ITER_W'(Q_W - 1);

  // Register reset values.
  localparam logic [NCH_W-1:0] ACTIVE_CHANNELS_RST = NCH_W'(3);
  localparam logic [CH_W-1:0]  TOLERANCE_RST       = CH_W'(40);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ACTIVE_CHANNELS = 1'b0,
    CFG_TOLERANCE       = 1'b1
  } cfg_index_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic count;
    logic capture;
    logic mul_load;
    logic div_step;
    logic out_load;
  } pms_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_last;
  } pms_status_t;

  // Absolute difference of two channel values.
  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Saturating increment at the counter bound.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= MAX_PIXELS) ? MAX_PIXELS : (v + CNT_W'(1));
  endfunction

endpackage

// ----- rtl/pms_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_ctrl: sequencer for the pixel match block
// Accepts pixel pairs while counting, then steps the datapath through the
// scaling multiply, the division and the hand-over to the output register.
// ----------------------------------------------------------------------------
module pms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 final_pixel,
  input  logic                 out_stall,
  input  pms_pkg::pms_status_t status,
  output logic                 in_stall,
  output logic                 out_valid,
  output pms_pkg::pms_cmd_t    cmd
);

  pms_pkg::state_t state;
  pms_pkg::state_t state_next;
  logic            out_free;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != pms_pkg::ST_RUN);

  // Commands.
  always_comb begin
    cmd          = '0;
    cmd.count    = in_valid && (state == pms_pkg::ST_RUN);
    cmd.capture  = cmd.count && final_pixel;
    cmd.mul_load = (state == pms_pkg::ST_MUL);
    cmd.div_step = (state == pms_pkg::ST_DIV);
    cmd.out_load = (state == pms_pkg::ST_HOLD) && out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pms_pkg::ST_RUN: begin
        if (cmd.capture) state_next = pms_pkg::ST_MUL;
      end
      pms_pkg::ST_MUL: begin
        state_next = pms_pkg::ST_DIV;
      end
      pms_pkg::ST_DIV: begin
        if (status.div_last) state_next = pms_pkg::ST_HOLD;
      end
      pms_pkg::ST_HOLD: begin
        if (out_free) state_next = pms_pkg::ST_RUN;
      end
      default: begin
        state_next = pms_pkg::ST_RUN;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pms_pkg::ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/pms_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_datapath: counters, scaling multiply and restoring divider
// Compares the active channels, keeps the saturating frame counters and
// works out matched * 25600 / frame one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pms_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  pms_pkg::pms_cmd_t                 cmd,
  output pms_pkg::pms_status_t              status,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [pms_pkg::CH_W-1:0]          cfg_data,
  input  logic [pms_pkg::CH_W-1:0]          first_ch0,
  input  logic [pms_pkg::CH_W-1:0]          first_ch1,
  input  logic [pms_pkg::CH_W-1:0]          first_ch2,
  input  logic [pms_pkg::CH_W-1:0]          first_ch3,
  input  logic [pms_pkg::CH_W-1:0]          second_ch0,
  input  logic [pms_pkg::CH_W-1:0]          second_ch1,
  input  logic [pms_pkg::CH_W-1:0]          second_ch2,
  input  logic [pms_pkg::CH_W-1:0]          second_ch3,
  output logic [pms_pkg::CNT_W-1:0]         matched_pixels,
  output logic [pms_pkg::CNT_W-1:0]         frame_pixels,
  output logic [pms_pkg::Q_W-1:0]           similarity_q8
);

  logic [pms_pkg::NCH_W-1:0]  active_channels;
  logic [pms_pkg::CH_W-1:0]   tolerance;
  logic [pms_pkg::CNT_W-1:0]  match_cnt;
  logic [pms_pkg::CNT_W-1:0]  pixel_cnt;
  logic [pms_pkg::CNT_W-1:0]  match_cnt_next;
  logic [pms_pkg::CNT_W-1:0]  pixel_cnt_next;
  logic [pms_pkg::CNT_W-1:0]  match_op;
  logic [pms_pkg::CNT_W-1:0]  pixel_op;
  logic [pms_pkg::CNT_W-1:0]  rem;
  logic [pms_pkg::Q_W-1:0]    low;
  logic [pms_pkg::Q_W-1:0]    quot;
  logic [pms_pkg::ITER_W-1:0] iter;
  logic [pms_pkg::PROD_W-1:0] prod;
  logic [pms_pkg::CNT_W:0]    trial;
  logic [pms_pkg::CNT_W:0]    trial_diff;
  logic                       trial_ok;
  logic [3:0]                 ch_fail;
  logic                       pix_match;

  // Channel compare; channel 0 always counts, higher ones by register value.
  always_comb begin
    ch_fail[0] = pms_pkg::abs_diff(first_ch0, second_ch0) > tolerance;
    ch_fail[1] = (pms_pkg::abs_diff(first_ch1, second_ch1) > tolerance)
                 && (active_channels >= pms_pkg::NCH_W'(2));
    ch_fail[2] = (pms_pkg::abs_diff(first_ch2, second_ch2) > tolerance)
                 && (active_channels >= pms_pkg::NCH_W'(3));
    ch_fail[3] = (pms_pkg::abs_diff(first_ch3, second_ch3) > tolerance)
                 && (active_channels >= pms_pkg::NCH_W'(4));
    pix_match  = (ch_fail == 4'b0000);
  end

  // Counter next values, including the item being accepted.
  assign pixel_cnt_next = pms_pkg::sat_inc(pixel_cnt);
  assign match_cnt_next = pix_match ? pms_pkg::sat_inc(match_cnt) : match_cnt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= pms_pkg::ACTIVE_CHANNELS_RST;
      tolerance       <= pms_pkg::TOLERANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pms_pkg::CFG_ACTIVE_CHANNELS: active_channels <= cfg_data[pms_pkg::NCH_W-1:0];
        pms_pkg::CFG_TOLERANCE:       tolerance       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame counters; cleared once the final item's counts are captured.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_cnt <= '0;
      pixel_cnt <= '0;
    end else if (cmd.capture) begin
      match_cnt <= '0;
      pixel_cnt <= '0;
    end else if (cmd.count) begin
      match_cnt <= match_cnt_next;
      pixel_cnt <= pixel_cnt_next;
    end
  end

  // Scaling multiply and one restoring division step.
  assign prod       = pms_pkg::PROD_W'(match_op) * pms_pkg::PROD_W'(pms_pkg::PCT_Q8);
  assign trial      = {rem, low[pms_pkg::Q_W-1]};
  assign trial_diff = trial - {1'b0, pixel_op};
  assign trial_ok   = (trial >= {1'b0, pixel_op});

  assign status.div_last = (iter == pms_pkg::LAST_ITER);

  // Operands and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_op <= match_cnt_next;
      pixel_op <= pixel_cnt_next;
    end
    if (cmd.mul_load) begin
      // The quotient fits in Q_W bits, so the upper part is below the divisor.
      rem  <= prod[pms_pkg::PROD_W-1:pms_pkg::Q_W];
      low  <= prod[pms_pkg::Q_W-1:0];
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= trial_ok ? trial_diff[pms_pkg::CNT_W-1:0] : trial[pms_pkg::CNT_W-1:0];
      low  <= {low[pms_pkg::Q_W-2:0], 1'b0};
      quot <= {quot[pms_pkg::Q_W-2:0], trial_ok};
    end
  end

  // Iteration counter for the division.
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.mul_load) begin
      iter <= '0;
    end else if (cmd.div_step) begin
      iter <= iter + pms_pkg::ITER_W'(1);
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      matched_pixels <= match_op;
      frame_pixels   <= pixel_op;
      similarity_q8  <= quot;
    end
  end

endmodule

// ----- rtl/pixel_match_similarity.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_match_similarity: frame match counter with percentage output
// Counts pixel pairs and pairs within tolerance; on the final pair of a
// frame it delivers both counts and the match percentage in unsigned Q8.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ----------------------------------------
//   in       in_valid / in_stall  first_ch0..3, second_ch0..3, final_pixel
//   out      out_valid/out_stall  matched_pixels, frame_pixels, similarity_q8
//   cfg      cfg_we               cfg_index, cfg_data
//
// Pixel pairs that are not final stream back to back.
// After a final pair no item is accepted until the multiply, the restoring
// divider and the output load are through.
// The output load waits while a previous result is still stalled.
// Reset is synchronous and restores the register defaults and clears the counters.
// ----------------------------------------------------------------------------
module pixel_match_similarity (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [pms_pkg::CH_W-1:0]          cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pms_pkg::CH_W-1:0]          first_ch0,
  input  logic [pms_pkg::CH_W-1:0]          first_ch1,
  input  logic [pms_pkg::CH_W-1:0]          first_ch2,
  input  logic [pms_pkg::CH_W-1:0]          first_ch3,
  input  logic [pms_pkg::CH_W-1:0]          second_ch0,
  input  logic [pms_pkg::CH_W-1:0]          second_ch1,
  input  logic [pms_pkg::CH_W-1:0]          second_ch2,
  input  logic [pms_pkg::CH_W-1:0]          second_ch3,
  input  logic                              final_pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pms_pkg::CNT_W-1:0]         matched_pixels,
  output logic [pms_pkg::CNT_W-1:0]         frame_pixels,
  output logic [pms_pkg::Q_W-1:0]           similarity_q8
);

  pms_pkg::pms_cmd_t    cmd;
  pms_pkg::pms_status_t status;

  // Sequencer.
  pms_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .final_pixel (final_pixel),
    .out_stall   (out_stall),
    .status      (status),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  // Counters, divider and output register.
  pms_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .first_ch0      (first_ch0),
    .first_ch1      (first_ch1),
    .first_ch2      (first_ch2),
    .first_ch3      (first_ch3),
    .second_ch0     (second_ch0),
    .second_ch1     (second_ch1),
    .second_ch2     (second_ch2),
    .second_ch3     (second_ch3),
    .matched_pixels (matched_pixels),
    .frame_pixels   (frame_pixels),
    .similarity_q8  (similarity_q8)
  );

  // A final item must hold off the input while its result is worked out.
  a_final_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_pixel |=> in_stall)
    else $error("input not stalled after a final item");

  // The match count never exceeds the frame count.
  a_match_le_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> matched_pixels <= frame_pixels)
    else $error("matched count above frame count");

  // A result always covers at least one pixel pair.
  a_frame_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_pixels != '0)
    else $error("result with an empty frame");

  // The percentage never exceeds one hundred.
  a_pct_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> similarity_q8 <= pms_pkg::PCT_Q8)
    else $error("similarity above one hundred percent");

endmodule

// ----- verif/pms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_checker: result predictor and comparator for the pixel match block
// Watches the register writes and both item channels, keeps its own frame
// counters and register copies, and compares each result item field by
// field with the oldest predicted frame summary.
// ----------------------------------------------------------------------------
module pms_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [pms_pkg::CH_W-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [pms_pkg::CH_W-1:0]  first_ch0,
  input  logic [pms_pkg::CH_W-1:0]  first_ch1,
  input  logic [pms_pkg::CH_W-1:0]  first_ch2,
  input  logic [pms_pkg::CH_W-1:0]  first_ch3,
  input  logic [pms_pkg::CH_W-1:0]  second_ch0,
  input  logic [pms_pkg::CH_W-1:0]  second_ch1,
  input  logic [pms_pkg::CH_W-1:0]  second_ch2,
  input  logic [pms_pkg::CH_W-1:0]  second_ch3,
  input  logic                      final_pixel,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [pms_pkg::CNT_W-1:0] matched_pixels,
  input  logic [pms_pkg::CNT_W-1:0] frame_pixels,
  input  logic [pms_pkg::Q_W-1:0]   similarity_q8,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic [pms_pkg::CNT_W-1:0] matched;
    logic [pms_pkg::CNT_W-1:0] total;
    logic [pms_pkg::Q_W-1:0]   q8;
  } frame_summary_t;

  // Shadow registers and frame counters.
  logic [pms_pkg::NCH_W-1:0] channels_reg;
  logic [pms_pkg::CH_W-1:0]  tolerance_reg;
  logic [pms_pkg::CNT_W-1:0] match_count;
  logic [pms_pkg::CNT_W-1:0] pair_count;
  int                        mismatch_count;
  frame_summary_t            frame_summaries_q[$];

  // Counters stick at the bound instead of wrapping.
  function automatic logic [pms_pkg::CNT_W-1:0] count_up(
      input logic [pms_pkg::CNT_W-1:0] v);
    if (v < pms_pkg::MAX_PIXELS) return v + pms_pkg::CNT_W'(1);
    return pms_pkg::MAX_PIXELS;
  endfunction

  // A pair matches when every compared channel lies within the tolerance.
  function automatic bit pair_within_tolerance(
      input logic [3:0][pms_pkg::CH_W-1:0] a,
      input logic [3:0][pms_pkg::CH_W-1:0] b);
    int n;
    int gap;
    n = int'(channels_reg);
    if (n < 1) n = 1;
    if (n > 4) n = 4;
    for (int c = 0; c < n; c++) begin
      gap = int'(a[c]) - int'(b[c]);
      if (gap < 0) gap = -gap;
      if (gap > int'(tolerance_reg)) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
    mismatch_count = 0;
  end

  always @(posedge clk) begin : watch
    frame_summary_t want;
    longint unsigned scaled;
    if (rst) begin
      channels_reg  = pms_pkg::ACTIVE_CHANNELS_RST;
      tolerance_reg = pms_pkg::TOLERANCE_RST;
      match_count   = '0;
      pair_count    = '0;
      frame_summaries_q.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          pms_pkg::CFG_ACTIVE_CHANNELS: channels_reg = cfg_data[pms_pkg::NCH_W-1:0];
          pms_pkg::CFG_TOLERANCE:       tolerance_reg = cfg_data;
          default: ;
        endcase
      end

      // Result items against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (frame_summaries_q.size() == 0) begin
          $error("unexpected result item: matched_pixels %0d frame_pixels %0d similarity_q8 %0d",
                 matched_pixels, frame_pixels, similarity_q8);
          mismatch_count++;
        end else begin
          want = frame_summaries_q.pop_front();
          if (matched_pixels !== want.matched) begin
            $error("matched_pixels: expected %0d, actual %0d", want.matched, matched_pixels);
            mismatch_count++;
          end
          if (frame_pixels !== want.total) begin
            $error("frame_pixels: expected %0d, actual %0d", want.total, frame_pixels);
            mismatch_count++;
          end
          if (similarity_q8 !== want.q8) begin
            $error("similarity_q8: expected %0d, actual %0d", want.q8, similarity_q8);
            mismatch_count++;
          end
        end
      end

      // Input items update the counters; a final pair closes the frame.
      if (in_valid && !in_stall) begin
        pair_count = count_up(pair_count);
        if (pair_within_tolerance({first_ch3, first_ch2, first_ch1, first_ch0},
                                  {second_ch3, second_ch2, second_ch1, second_ch0}))
          match_count = count_up(match_count);
        if (final_pixel) begin
          scaled       = longint'(match_count) * longint'(pms_pkg::PCT_Q8);
          want.matched = match_count;
          want.total   = pair_count;
          want.q8      = pms_pkg::Q_W'(scaled / longint'(pair_count));
          frame_summaries_q.push_back(want);
          match_count = '0;
          pair_count  = '0;
        end
      end
    end
    errors  <= mismatch_count;
    pending <= frame_summaries_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the pixel match similarity block
// Sends directed frames around the tolerance and channel-count edges, then
// random frames under several register settings and idling patterns. A
// separate checker predicts every frame summary and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 30;
  localparam int PHASES       = 8;
  localparam int PHASE_PAIRS  = 96;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [0:0]                cfg_index = pms_pkg::CFG_ACTIVE_CHANNELS;
  logic [pms_pkg::CH_W-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [pms_pkg::CH_W-1:0]  first_ch0 = '0, first_ch1 = '0;
  logic [pms_pkg::CH_W-1:0]  first_ch2 = '0, first_ch3 = '0;
  logic [pms_pkg::CH_W-1:0]  second_ch0 = '0, second_ch1 = '0;
  logic [pms_pkg::CH_W-1:0]  second_ch2 = '0, second_ch3 = '0;
  logic                      final_pixel = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [pms_pkg::CNT_W-1:0] matched_pixels;
  logic [pms_pkg::CNT_W-1:0] frame_pixels;
  logic [pms_pkg::Q_W-1:0]   similarity_q8;

  int errors;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cur_tolerance = 40;

  // Phase table: channel count, tolerance (negative picks one at random),
  // sender idle and receiver stall percentages.
  int ph_channels[PHASES] = '{4, 1, 0, 7, 2, 3, 5, 4};
  int ph_tol[PHASES]      = '{0, 255, 17, 200, 40, -1, -1, -1};
  int ph_idle[PHASES]     = '{0, 76, 0, 17, 0, 76, 0, 17};
  int ph_stall[PHASES]    = '{0, 0, 76, 17, 0, 0, 76, 17};

  pixel_match_similarity dut (.*);

  pms_checker u_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Offer one pixel pair and hold it until it is accepted.
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    {first_ch3, first_ch2, first_ch1, first_ch0}     = a;
    {second_ch3, second_ch2, second_ch1, second_ch0} = b;
    final_pixel = last;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every frame summary has come back.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Both registers are written while the block is idle.
  task automatic write_regs(input int channels, input int tol);
    settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = pms_pkg::CFG_ACTIVE_CHANNELS;
    cfg_data  = pms_pkg::CH_W'(channels);
    @(negedge clk);
    cfg_index = pms_pkg::CFG_TOLERANCE;
    cfg_data  = pms_pkg::CH_W'(tol);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_tolerance = tol;
  endtask

  // Random pair: mostly channel differences near the tolerance edge.
  task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
    int mode;
    int delta;
    int v;
    mode = $urandom_range(99);
    a = $urandom;
    b = $urandom;
    if (mode < 10) begin
      b = a;
    end else if (mode >= 20) begin
      for (int c = 0; c < 4; c++) begin
        delta = $urandom_range(2 * cur_tolerance + 2);
        delta = delta - cur_tolerance - 1;
        v = int'(a[c*8 +: 8]) + delta;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        b[c*8 +: 8] = 8'(v);
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] a;
    logic [31:0] b;
    int frame_len;
    int sent;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames with the reset settings: three channels, tolerance 40.
    send_pair(32'h00000000, 32'h00000000, 1'b1);
    send_pair(32'h000000FF, 32'h00000000, 1'b1);
    send_pair(32'hFF280000, 32'h00000000, 1'b0);   // diff of exactly 40, ch3 ignored
    send_pair(32'h00002900, 32'h00000000, 1'b0);   // diff of 41
    send_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    send_pair(32'h00000000, 32'h00000029, 1'b1);   // second larger than first

    // Channel count of zero behaves as one channel; tolerance of zero.
    write_regs(0, 0);
    send_pair(32'hFFFFFF05, 32'h00000005, 1'b0);
    send_pair(32'h00000006, 32'h00000005, 1'b0);
    send_pair(32'h00000004, 32'h00000005, 1'b1);

    // Channel count above four behaves as four; widest tolerance.
    write_regs(7, 255);
    send_pair(32'hFFFFFFFF, 32'h00000000, 1'b1);
    send_pair(32'h00000000, 32'hFFFFFFFF, 1'b0);
    send_pair(32'h12345678, 32'h9ABCDEF0, 1'b1);

    // Four channels with tolerance one below the widest.
    write_regs(4, 254);
    send_pair(32'hFFFFFFFF, 32'h00000000, 1'b0);
    send_pair(32'hFEFEFEFE, 32'h00000000, 1'b0);
    send_pair(32'h00000000, 32'hFF000000, 1'b0);
    send_pair(32'h01010101, 32'hFFFFFFFF, 1'b1);

    // Random frames under each phase setting.
    for (int p = 0; p < PHASES; p++) begin
      write_regs(ph_channels[p], (ph_tol[p] < 0) ? int'($urandom_range(255)) : ph_tol[p]);
      send_idle_pct  = ph_idle[p];
      recv_stall_pct = ph_stall[p];
      sent = 0;
      while (sent < PHASE_PAIRS) begin
        if ($urandom_range(9) != 0) frame_len = $urandom_range(1, 12);
        else frame_len = $urandom_range(13, 60);
        for (int i = 0; i < frame_len; i++) begin
          random_pair(a, b);
          send_pair(a, b, i == frame_len - 1);
        end
        sent += frame_len;
        if ($urandom_range(15) == 0) settle();
      end
    end

    settle();
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pms_pkg.sv
rtl/pms_ctrl.sv
rtl/pms_datapath.sv
rtl/pixel_match_similarity.sv
verif/pms_checker.sv
verif/testbench.sv
